FILE: design/assert_macros.svh
// assertion macros used by the converter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition on this edge implies a consequent on the same edge
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// condition on this edge implies a consequent on the next edge
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/btm_pkg.sv
// types, constants and helper functions for the bcd time message converter
`default_nettype none

package btm_pkg;

  // date format codes
  localparam logic FMT_DOY = 1'b0;
  localparam logic FMT_DMY = 1'b1;

  // day-of-year mode: days from 1970-01-01 to 1 january, minus one
  localparam logic [11:0] DOY_BASE_1971 = 12'd364;
  localparam logic [11:0] DOY_BASE_1972 = 12'd729;
  localparam logic [10:0] YDAY_MAX_COMMON = 11'd365;
  localparam logic [10:0] YDAY_MAX_LEAP   = 11'd366;

  // march-based year shifted up by one 400-year era
  localparam logic [14:0] YEAR_SHIFT = 15'd400;
  // day offset of the shifted calendar from 1970-01-01, plus one for day 1
  localparam logic [24:0] DAY_OFFSET = 25'd865566;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

  // reciprocal of 100: (yy * 5243) >> 19 is exact for yy up to 10399
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic signed [17:0] SEC_PER_DAY = 18'sd86400;
  localparam logic [23:0] TICKS_100MS = 24'd1000000;
  localparam logic [23:0] TICKS_10MS  = 24'd100000;

  // decoded message, first pipeline stage
  typedef struct packed {
    logic        bad;
    logic        fmt;
    logic        leap;
    logic [19:0] tod;
    logic [23:0] ticks;
    logic [10:0] yday;
    logic [7:0]  mday;
    logic [8:0]  mdays;
    logic [14:0] yy;
  } dec_t;

  // days from 1 march to the first of the month
  function automatic logic [8:0] march_days(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd3:    d = 9'd0;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      4'd1:    d = 9'd306;
      4'd2:    d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic digit_bad(input logic [3:0] d);
    return d > 4'd9;
  endfunction

  function automatic logic pair_bad(input logic [7:0] b);
    return digit_bad(b[7:4]) | digit_bad(b[3:0]);
  endfunction

  function automatic logic [7:0] bcd2(input logic [7:0] b);
    return (8'(b[7:4]) * 8'd10) + 8'(b[3:0]);
  endfunction

endpackage

`default_nettype wire

FILE: design/btm_decode.sv
// bcd digit decode, range checks and day-of-month calendar setup
`default_nettype none

module btm_decode (
  input  wire logic        format_sel,
  input  wire logic        leap_sel,
  input  wire logic [7:0]  seconds_bcd,
  input  wire logic [7:0]  minutes_bcd,
  input  wire logic [7:0]  hours_bcd,
  input  wire logic [11:0] day_bcd,
  input  wire logic [7:0]  month_bcd,
  input  wire logic [15:0] year_bcd,
  input  wire logic [7:0]  fraction_bcd,
  output btm_pkg::dec_t    dec
);
  import btm_pkg::*;

  logic [7:0]  sec_v, min_v, hour_v, mday_v, month_v;
  logic [10:0] yday_v;
  logic [14:0] year_v;
  logic        time_bad, doy_bad, dmy_bad, month_range_bad, yday_big;

  // two-digit fields
  assign sec_v   = bcd2(seconds_bcd);
  assign min_v   = bcd2(minutes_bcd);
  assign hour_v  = bcd2(hours_bcd);
  assign mday_v  = bcd2(day_bcd[7:0]);
  assign month_v = bcd2(month_bcd);

  // three-digit day of year and four-digit year
  assign yday_v = (11'(day_bcd[11:8]) * 11'd100) + (11'(day_bcd[7:4]) * 11'd10)
                + 11'(day_bcd[3:0]);
  assign year_v = (15'(year_bcd[15:12]) * 15'd1000) + (15'(year_bcd[11:8]) * 15'd100)
                + (15'(year_bcd[7:4]) * 15'd10) + 15'(year_bcd[3:0]);

  // error checks per format
  assign time_bad = pair_bad(seconds_bcd) | pair_bad(minutes_bcd) | pair_bad(hours_bcd)
                  | pair_bad(fraction_bcd);
  assign yday_big = yday_v > (leap_sel ? YDAY_MAX_LEAP : YDAY_MAX_COMMON);
  assign doy_bad  = digit_bad(day_bcd[11:8]) | pair_bad(day_bcd[7:0]) | yday_big;
  assign month_range_bad = (month_v < 8'd1) | (month_v > 8'd12);
  assign dmy_bad  = pair_bad(day_bcd[7:0]) | pair_bad(month_bcd) | pair_bad(year_bcd[15:8])
                  | pair_bad(year_bcd[7:0]) | month_range_bad;

  // pack decoded word
  always_comb begin
    dec.bad   = time_bad | ((format_sel == FMT_DMY) ? dmy_bad : doy_bad);
    dec.fmt   = format_sel;
    dec.leap  = leap_sel;
    dec.tod   = (20'(hour_v) * 20'd3600) + (20'(min_v) * 20'd60) + 20'(sec_v);
    dec.ticks = (24'(fraction_bcd[7:4]) * TICKS_100MS) + (24'(fraction_bcd[3:0]) * TICKS_10MS);
    dec.yday  = yday_v;
    dec.mday  = mday_v;
    dec.mdays = march_days(month_v[3:0]);
    // january and february belong to the previous march-based year
    dec.yy    = year_v + YEAR_SHIFT - ((month_v <= 8'd2) ? 15'd1 : 15'd0);
  end

endmodule

`default_nettype wire

FILE: design/bcd_time_message_to_epoch_core.sv
// bcd time message to epoch seconds converter, four-stage pipeline
//
// Takes one message per clock: a word is accepted when start is high and
// busy is low, and busy never rises, so a new word may be sent every cycle.
// Each result is driven onto the out_ ports by the fourth register stage;
// out_valid marks it for one cycle, in input order, and the
// receiver cannot stall it. The four stages are bcd decode, the divide by
// 100 (a reciprocal multiply) with the 365-day product, the calendar sum,
// and the multiply by 86400. On error both result values read zero.
`default_nettype none

`include "assert_macros.svh"

module bcd_time_message_to_epoch_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_format_sel,
  input  wire logic               in_leap_sel,
  input  wire logic [7:0]         in_seconds_bcd,
  input  wire logic [7:0]         in_minutes_bcd,
  input  wire logic [7:0]         in_hours_bcd,
  input  wire logic [11:0]        in_day_bcd,
  input  wire logic [7:0]         in_month_bcd,
  input  wire logic [15:0]        in_year_bcd,
  input  wire logic [7:0]         in_fraction_bcd,
  output logic                    out_valid,
  output logic signed [38:0]      out_epoch_seconds,
  output logic [23:0]             out_fraction_ticks,
  output logic                    out_format_out,
  output logic                    out_error
);
  import btm_pkg::*;

  dec_t        dec_nxt, s1_r, s2_r;
  logic        v1_r, v2_r, v3_r, v4_r;
  logic [26:0] q_prod;
  logic [7:0]  q100_nxt, q100_r;
  logic [23:0] part_nxt, part_r;
  logic [11:0] doy_days_nxt, doy_days_r;
  logic [24:0] dmy_days;
  logic signed [23:0] days_nxt, days_r;
  logic        bad3_r, fmt3_r;
  logic [19:0] tod3_r;
  logic [23:0] ticks3_r;
  logic [41:0] total;
  logic signed [38:0] epoch_nxt, epoch_r;
  logic [23:0] ticks_nxt, ticks_r;
  logic        fmt4_r, bad4_r;
  logic        chk_err_zero, chk_doy_word, chk_doy_range;

  // the pipeline never holds off a word
  assign busy = 1'b0;

  // stage 1: digit decode
  btm_decode u_decode (
    .format_sel   (in_format_sel),
    .leap_sel     (in_leap_sel),
    .seconds_bcd  (in_seconds_bcd),
    .minutes_bcd  (in_minutes_bcd),
    .hours_bcd    (in_hours_bcd),
    .day_bcd      (in_day_bcd),
    .month_bcd    (in_month_bcd),
    .year_bcd     (in_year_bcd),
    .fraction_bcd (in_fraction_bcd),
    .dec          (dec_nxt)
  );

  // stage 2: centuries by reciprocal, linear part of the day count
  assign q_prod       = 27'(s1_r.yy) * 27'(RECIP_100);
  assign q100_nxt     = q_prod[RECIP_SHIFT +: 8];
  assign part_nxt     = (24'(s1_r.yy) * 24'(DAYS_PER_YEAR)) + 24'(s1_r.yy[14:2])
                      + 24'(s1_r.mdays) + 24'(s1_r.mday);
  assign doy_days_nxt = (s1_r.leap ? DOY_BASE_1972 : DOY_BASE_1971) + 12'(s1_r.yday);

  // stage 3: leap corrections and offset to 1970
  assign dmy_days = 25'(part_r) + 25'(q100_r[7:2]) - 25'(q100_r) - DAY_OFFSET;
  assign days_nxt = (s2_r.fmt == FMT_DMY) ? $signed(dmy_days[23:0])
                                          : $signed({12'd0, doy_days_r});

  // stage 4: seconds of the day count plus time of day, zero on error
  assign total     = (42'(days_r) * 42'(SEC_PER_DAY)) + 42'(tod3_r);
  assign epoch_nxt = bad3_r ? '0 : $signed(total[38:0]);
  assign ticks_nxt = bad3_r ? '0 : ticks3_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage data registers
  always_ff @(posedge clk) begin
    s1_r       <= dec_nxt;
    s2_r       <= s1_r;
    q100_r     <= q100_nxt;
    part_r     <= part_nxt;
    doy_days_r <= doy_days_nxt;
    days_r     <= days_nxt;
    bad3_r     <= s2_r.bad;
    fmt3_r     <= s2_r.fmt;
    tod3_r     <= s2_r.tod;
    ticks3_r   <= s2_r.ticks;
    epoch_r    <= epoch_nxt;
    ticks_r    <= ticks_nxt;
    fmt4_r     <= fmt3_r;
    bad4_r     <= bad3_r;
  end

  // result ports
  assign out_valid          = v4_r;
  assign out_epoch_seconds  = epoch_r;
  assign out_fraction_ticks = ticks_r;
  assign out_format_out     = fmt4_r;
  assign out_error          = bad4_r;

  // checks
  assign chk_err_zero  = (out_epoch_seconds == '0) && (out_fraction_ticks == '0);
  assign chk_doy_word  = out_valid && !out_error && (out_format_out == FMT_DOY);
  assign chk_doy_range = (out_epoch_seconds >= 39'sd31449600)
                      && (out_epoch_seconds <= 39'sd95212065);
  `ASSERT_IMPLIES(a_err_zero, clk, rst_n, out_valid && out_error, chk_err_zero)
  `ASSERT_NEXT(a_valid_flow, clk, rst_n, v3_r, out_valid)
  `ASSERT_IMPLIES(a_doy_range, clk, rst_n, chk_doy_word, chk_doy_range)

endmodule

`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for the bcd time message to epoch converter
`default_nettype none

module tb;

  // one bcd time message as presented on the in_ ports
  typedef struct {
    logic        fmt;
    logic        leap;
    logic [7:0]  seconds;
    logic [7:0]  minutes;
    logic [7:0]  hours;
    logic [11:0] day;
    logic [7:0]  month;
    logic [15:0] year;
    logic [7:0]  fraction;
  } time_msg_t;

  // one converted time as seen on the out_ ports
  typedef struct {
    logic [38:0] epoch;
    logic [23:0] ticks;
    logic        fmt;
    logic        error;
  } epoch_result_t;

  // expected conversions, predicted when a word is accepted
  class epoch_scoreboard;
    epoch_result_t expected_times[$];
    int unsigned   fails;

    function new();
      fails = 0;
    endfunction

    function int unsigned pending();
      return expected_times.size();
    endfunction

    task report(string what);
      fails++;
      if (fails <= 100) $display("error: %s", what);
    endtask

    // decode the lowest ndig digits, flag any digit above nine
    function longint digits_value(logic [15:0] v, int ndig, inout bit bad);
      longint     acc;
      logic [3:0] d;
      acc = 0;
      for (int k = ndig - 1; k >= 0; k--) begin
        d = v[4*k +: 4];
        if (d > 4'd9) bad = 1'b1;
        acc = acc * 10 + longint'(d);
      end
      return acc;
    endfunction

    // days from 1970-01-01 to the first of a month, proleptic gregorian
    function longint days_before_month(longint yr, longint mon);
      longint yy, era, yoe, mp, doy, doe;
      yy  = yr + 400 - ((mon <= 2) ? 1 : 0);
      era = yy / 400;
      yoe = yy - era * 400;
      mp  = (mon + 9) % 12;
      doy = (153 * mp + 2) / 5;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468 - 146097;
    endfunction

    function epoch_result_t convert_message(time_msg_t m);
      bit            bad;
      longint        sec, mnt, hr, frac, yday, mday, mon, yr, days, total;
      epoch_result_t r;
      bad  = 1'b0;
      sec  = digits_value(16'(m.seconds), 2, bad);
      mnt  = digits_value(16'(m.minutes), 2, bad);
      hr   = digits_value(16'(m.hours), 2, bad);
      frac = digits_value(16'(m.fraction), 2, bad);
      if (m.fmt == btm_pkg::FMT_DOY) begin
        // fixed year, day count from 1 january
        yday = digits_value(16'(m.day), 3, bad);
        yr   = m.leap ? 1972 : 1971;
        if (yday > (m.leap ? 366 : 365)) bad = 1'b1;
        days = days_before_month(yr, 1) + yday - 1;
      end else begin
        mday = digits_value(16'(m.day[7:0]), 2, bad);
        mon  = digits_value(16'(m.month), 2, bad);
        yr   = digits_value(m.year, 4, bad);
        if (mon < 1 || mon > 12) bad = 1'b1;
        days = bad ? 0 : days_before_month(yr, mon) + mday - 1;
      end
      total   = days * 86400 + hr * 3600 + mnt * 60 + sec;
      r.fmt   = m.fmt;
      r.error = bad;
      r.epoch = bad ? 39'd0 : total[38:0];
      r.ticks = bad ? 24'd0 : 24'((frac / 10) * 1000000 + (frac % 10) * 100000);
      return r;
    endfunction

    function void note_message(time_msg_t m);
      expected_times.push_back(convert_message(m));
    endfunction

    task check_result(epoch_result_t got);
      epoch_result_t want;
      if (expected_times.size() == 0) begin
        report("result with no word waiting");
        return;
      end
      want = expected_times.pop_front();
      if (got.epoch !== want.epoch)
        report($sformatf("epoch seconds %0d, want %0d",
                         $signed(got.epoch), $signed(want.epoch)));
      if (got.ticks !== want.ticks)
        report($sformatf("fraction ticks %0d, want %0d", got.ticks, want.ticks));
      if (got.fmt !== want.fmt)
        report($sformatf("format %b, want %b", got.fmt, want.fmt));
      if (got.error !== want.error)
        report($sformatf("error flag %b, want %b", got.error, want.error));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_format_sel = 1'b0;
  logic               in_leap_sel = 1'b0;
  logic [7:0]         in_seconds_bcd = '0;
  logic [7:0]         in_minutes_bcd = '0;
  logic [7:0]         in_hours_bcd = '0;
  logic [11:0]        in_day_bcd = '0;
  logic [7:0]         in_month_bcd = '0;
  logic [15:0]        in_year_bcd = '0;
  logic [7:0]         in_fraction_bcd = '0;
  logic               out_valid;
  logic signed [38:0] out_epoch_seconds;
  logic [23:0]        out_fraction_ticks;
  logic               out_format_out;
  logic               out_error;

  epoch_scoreboard board = new();
  time_msg_t       directed_q[$];
  int unsigned     burst_left = 0;

  bcd_time_message_to_epoch_core DUT (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      board.check_result('{out_epoch_seconds, out_fraction_ticks, out_format_out, out_error});
  end

  function automatic logic [15:0] to_bcd(int unsigned v);
    logic [15:0] b;
    for (int k = 0; k < 4; k++) begin
      b[4*k +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return b;
  endfunction

  function automatic time_msg_t make_msg(logic fmt, logic leap, logic [7:0] s,
                                         logic [7:0] mi, logic [7:0] h, logic [11:0] d,
                                         logic [7:0] mo, logic [15:0] y, logic [7:0] f);
    time_msg_t m;
    m.fmt = fmt; m.leap = leap; m.seconds = s; m.minutes = mi; m.hours = h;
    m.day = d; m.month = mo; m.year = y; m.fraction = f;
    return m;
  endfunction

  function automatic time_msg_t noise_message();
    return make_msg(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
  endfunction

  // year biased toward the ends of the range and the recent centuries
  function automatic int unsigned pick_year();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 3);
    if (r < 20) return $urandom_range(9996, 9999);
    if (r < 60) return $urandom_range(1900, 2100);
    return $urandom_range(0, 9999);
  endfunction

  // valid digits, mostly in calendar range, ignored fields left random
  function automatic time_msg_t well_formed_message();
    time_msg_t m;
    m = noise_message();
    m.seconds  = 8'(to_bcd(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                          : $urandom_range(0, 59)));
    m.minutes  = 8'(to_bcd(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                          : $urandom_range(0, 59)));
    m.hours    = 8'(to_bcd(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                          : $urandom_range(0, 23)));
    m.fraction = 8'(to_bcd($urandom_range(0, 99)));
    if (m.fmt == btm_pkg::FMT_DOY) begin
      m.day = 12'(to_bcd(($urandom_range(0, 7) == 0) ? $urandom_range(360, 366)
                                                       : $urandom_range(0, 366)));
    end else begin
      m.day[7:0] = 8'(to_bcd(($urandom_range(0, 5) == 0) ? $urandom_range(0, 99)
                                                           : $urandom_range(0, 31)));
      m.month    = 8'(to_bcd($urandom_range(1, 12)));
      m.year     = to_bcd(pick_year());
    end
    return m;
  endfunction

  // break one used field of a well-formed message
  function automatic time_msg_t broken_message();
    time_msg_t  m;
    logic [3:0] nib;
    int         idx;
    m   = well_formed_message();
    nib = 4'($urandom_range(10, 15));
    idx = $urandom_range(0, 1);
    case ($urandom_range(0, 5))
      0: m.seconds[4*idx +: 4] = nib;
      1: m.minutes[4*idx +: 4] = nib;
      2: m.hours[4*idx +: 4] = nib;
      3: m.fraction[4*idx +: 4] = nib;
      4: begin
        if (m.fmt == btm_pkg::FMT_DOY) m.day[4*$urandom_range(0, 2) +: 4] = nib;
        else m.day[4*idx +: 4] = nib;
      end
      default: begin
        if (m.fmt == btm_pkg::FMT_DOY) m.day = 12'(to_bcd($urandom_range(366, 999)));
        else if (idx == 0) m.month = 8'(to_bcd($urandom_range(0, 1) ? 0 : $urandom_range(13, 99)));
        else m.year[4*$urandom_range(0, 3) +: 4] = nib;
      end
    endcase
    return m;
  endfunction

  // present one word and hold it until accepted
  task automatic send_message(time_msg_t m);
    start           <= 1'b1;
    in_format_sel   <= m.fmt;
    in_leap_sel     <= m.leap;
    in_seconds_bcd  <= m.seconds;
    in_minutes_bcd  <= m.minutes;
    in_hours_bcd    <= m.hours;
    in_day_bcd      <= m.day;
    in_month_bcd    <= m.month;
    in_year_bcd     <= m.year;
    in_fraction_bcd <= m.fraction;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_message(m);
  endtask

  // random gap between words: mostly none or short, a few long, some bursts
  task automatic pace();
    int unsigned r, gap;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (r < 3) begin
      burst_left = $urandom_range(20, 40);
      gap = 0;
    end else if (r < 55) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start           <= 1'b0;
      in_format_sel   <= 1'($urandom);
      in_day_bcd      <= 12'($urandom);
      in_year_bcd     <= 16'($urandom);
      in_seconds_bcd  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every expected result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin
    // limits, day zero, too-large day of year, bad digits, ignored fields
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 0, 8'h00, 8'h00, 8'h00, 12'h001, 8'h01, 16'h0000, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 0, 8'h59, 8'h59, 8'h23, 12'h031, 8'h12, 16'h9999, 8'h99));
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 0, 8'h00, 8'h00, 8'h00, 12'h001, 8'h01, 16'h1970, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 0, 8'h01, 8'h02, 8'h03, 12'h000, 8'h03, 16'h2000, 8'h10));
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 0, 8'h99, 8'h99, 8'h99, 12'h099, 8'h12, 16'h9999, 8'h09));
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 0, 8'h00, 8'h00, 8'h00, 12'h001, 8'h00, 16'h2020, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 0, 8'h00, 8'h00, 8'h00, 12'h001, 8'h13, 16'h2020, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 1, 8'h30, 8'h15, 8'h12, 12'hF29, 8'h02, 16'h2000, 8'h55));
    directed_q.push_back(make_msg(btm_pkg::FMT_DOY, 0, 8'h00, 8'h00, 8'h00, 12'h000, 8'h00, 16'h0000, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DOY, 0, 8'h59, 8'h59, 8'h23, 12'h365, 8'h00, 16'h0000, 8'h99));
    directed_q.push_back(make_msg(btm_pkg::FMT_DOY, 0, 8'h00, 8'h00, 8'h00, 12'h366, 8'h00, 16'h0000, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DOY, 1, 8'h00, 8'h00, 8'h00, 12'h366, 8'h00, 16'h0000, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DOY, 1, 8'h00, 8'h00, 8'h00, 12'h367, 8'h00, 16'h0000, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DOY, 1, 8'h45, 8'h30, 8'h06, 12'h001, 8'hFF, 16'hFFFF, 8'h40));
    directed_q.push_back(make_msg(btm_pkg::FMT_DOY, 1, 8'h00, 8'h00, 8'h00, 12'h999, 8'h00, 16'h0000, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DOY, 0, 8'h00, 8'h00, 8'h00, 12'hF01, 8'h00, 16'h0000, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 0, 8'h5A, 8'h00, 8'h00, 12'h001, 8'h01, 16'h2001, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DOY, 0, 8'h00, 8'hA0, 8'h00, 12'h100, 8'h00, 16'h0000, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 0, 8'h00, 8'h00, 8'hF0, 12'h001, 8'h01, 16'h2001, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DOY, 0, 8'h00, 8'h00, 8'h00, 12'h200, 8'h00, 16'h0000, 8'h0F));
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 0, 8'h00, 8'h00, 8'h00, 12'h015, 8'h06, 16'h19A0, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 0, 8'h00, 8'h00, 8'h00, 12'h03F, 8'h06, 16'h1999, 8'h00));
    directed_q.push_back(make_msg(btm_pkg::FMT_DMY, 1, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF));
    directed_q.push_back(make_msg(btm_pkg::FMT_DOY, 1, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF));

    // reset
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed words
    foreach (directed_q[i]) begin
      send_message(directed_q[i]);
      pace();
    end
    drain_results();

    // random words: mostly well formed, some broken, some noise
    for (int n = 0; n < 1050; n++) begin
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) send_message(noise_message());
      else if (r < 25) send_message(broken_message());
      else send_message(well_formed_message());
      pace();
      if (n % 350 == 349) drain_results();
    end
    drain_results();
    repeat (8) @(posedge clk);

    if (board.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+design
design/btm_pkg.sv
design/btm_decode.sv
design/bcd_time_message_to_epoch_core.sv
tb/tb.sv
